@@ rtl/core/tpd_pkg.sv @@
// Package: beat types, widths and integer compare constants of the timing pulse detector.
`default_nettype none
package tpd_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAME_BITS  = 16;
  localparam int CNT_BITS    = 16;
  localparam int TOTAL_BITS  = 40;
  localparam int CMP_BITS    = 32;

  localparam logic signed [TOTAL_BITS-1:0] TOTAL_MAX = {1'b0, {(TOTAL_BITS-1){1'b1}}};
  localparam logic signed [TOTAL_BITS-1:0] TOTAL_MIN = {1'b1, {(TOTAL_BITS-1){1'b0}}};
  localparam logic [CNT_BITS-1:0]          CNT_MAX   = {CNT_BITS{1'b1}};

  // rise: 2*old < mid, 2*old < new, 20*new > 11*peak
  localparam logic signed [CMP_BITS-1:0] K_HALF   = 32'sd2;
  localparam logic signed [CMP_BITS-1:0] K_NEW    = 32'sd20;
  localparam logic signed [CMP_BITS-1:0] K_RISE   = 32'sd11;
  // fall: 50*old > 53*mid, old > 20*new, 20*new < peak
  localparam logic signed [CMP_BITS-1:0] K_OLD    = 32'sd50;
  localparam logic signed [CMP_BITS-1:0] K_MID    = 32'sd53;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] flux_sample;
    logic        [FRAME_BITS-1:0]  frame_number;
  } tpd_in_t;

  typedef struct packed {
    logic        [15:0]           start_position;
    logic        [FRAME_BITS-1:0] start_frame;
    logic        [CNT_BITS-1:0]   sample_count;
    logic signed [TOTAL_BITS-1:0] flux_total;
    logic        [15:0]           pulse_number;
    logic                         zero_total;
  } tpd_out_t;

  typedef struct packed {
    logic rise_ok;
    logic fall_ok;
  } tpd_edge_t;

endpackage
`default_nettype wire

@@ rtl/core/tpd_edge_cmp.sv @@
// Edge compares on the three-sample window against the peak level.
`default_nettype none
module tpd_edge_cmp (
  input  logic signed [tpd_pkg::SAMPLE_BITS-1:0] oldest,
  input  logic signed [tpd_pkg::SAMPLE_BITS-1:0] middle,
  input  logic signed [tpd_pkg::SAMPLE_BITS-1:0] newest,
  input  logic signed [tpd_pkg::SAMPLE_BITS-1:0] peak,
  output tpd_pkg::tpd_edge_t                     edges
);
  import tpd_pkg::*;

  logic signed [CMP_BITS-1:0] old_w, mid_w, new_w, peak_w;
  logic signed [CMP_BITS-1:0] old2, new20;

  assign old_w  = CMP_BITS'(oldest);
  assign mid_w  = CMP_BITS'(middle);
  assign new_w  = CMP_BITS'(newest);
  assign peak_w = CMP_BITS'(peak);
  assign old2   = K_HALF * old_w;
  assign new20  = K_NEW * new_w;

  assign edges.rise_ok = (old2 < mid_w) && (old2 < new_w) && (new20 > K_RISE * peak_w);
  assign edges.fall_ok = (K_OLD * old_w > K_MID * mid_w) && (old_w > new20) &&
                         (new20 < peak_w);

endmodule
`default_nettype wire

@@ rtl/core/tpd_pulse_acc.sv @@
// Window state, pulse accumulator and result formation for one step per beat.
`default_nettype none
module tpd_pulse_acc #(
  parameter int MAX_SAMPLES = 65536
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   step,
  input  tpd_pkg::tpd_in_t                       beat,
  input  logic signed [tpd_pkg::SAMPLE_BITS-1:0] peak,
  output logic                                   emit,
  output tpd_pkg::tpd_out_t                      result
);
  import tpd_pkg::*;

  localparam int SEEN_BITS = $clog2(MAX_SAMPLES + 1);

  logic signed [SAMPLE_BITS-1:0] oldest_r, middle_r;
  logic [SEEN_BITS-1:0]          seen_r;
  logic                          in_pulse_r, halted_r;
  logic signed [TOTAL_BITS-1:0]  total_r;
  logic [CNT_BITS-1:0]           count_r;
  logic [15:0]                   begin_pos_r;
  logic [FRAME_BITS-1:0]         begin_frame_r;
  logic [15:0]                   pulses_r;

  tpd_edge_t                     edges;
  logic                          active, tested, rise, pulse_now, closing, zero;
  logic [SEEN_BITS-1:0]          pos_m1;
  logic [SEEN_BITS+15:0]         pos_ext;
  logic [15:0]                   pos16;
  logic signed [TOTAL_BITS:0]    sum_w;
  logic signed [TOTAL_BITS-1:0]  total_nxt;
  logic [CNT_BITS-1:0]           count_nxt;

  tpd_edge_cmp u_edge (
    .oldest (oldest_r),
    .middle (middle_r),
    .newest (beat.flux_sample),
    .peak   (peak),
    .edges  (edges)
  );

  assign active    = !halted_r && (seen_r != SEEN_BITS'(MAX_SAMPLES));
  assign tested    = active && (seen_r >= SEEN_BITS'(2));
  assign rise      = tested && !in_pulse_r && edges.rise_ok;
  assign pulse_now = tested && (in_pulse_r || rise);
  assign closing   = pulse_now && edges.fall_ok;

  assign pos_m1  = seen_r - SEEN_BITS'(1);
  assign pos_ext = {16'b0, pos_m1};
  assign pos16   = pos_ext[15:0];

  assign sum_w = (TOTAL_BITS+1)'(total_r) + (TOTAL_BITS+1)'(middle_r);
  always_comb begin
    if (sum_w > (TOTAL_BITS+1)'(TOTAL_MAX)) begin
      total_nxt = TOTAL_MAX;
    end else if (sum_w < (TOTAL_BITS+1)'(TOTAL_MIN)) begin
      total_nxt = TOTAL_MIN;
    end else begin
      total_nxt = sum_w[TOTAL_BITS-1:0];
    end
  end
  assign count_nxt = (count_r == CNT_MAX) ? count_r : count_r + CNT_BITS'(1);
  assign zero      = (total_nxt == '0);

  assign emit                  = step && closing;
  assign result.start_position = rise ? pos16 : begin_pos_r;
  assign result.start_frame    = rise ? beat.frame_number : begin_frame_r;
  assign result.sample_count   = count_nxt;
  assign result.flux_total     = total_nxt;
  assign result.pulse_number   = pulses_r;
  assign result.zero_total     = zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r      <= '0;
      middle_r      <= '0;
      seen_r        <= '0;
      in_pulse_r    <= 1'b0;
      halted_r      <= 1'b0;
      total_r       <= '0;
      count_r       <= '0;
      begin_pos_r   <= '0;
      begin_frame_r <= '0;
      pulses_r      <= '0;
    end else if (step && active) begin
      oldest_r <= middle_r;
      middle_r <= beat.flux_sample;
      seen_r   <= seen_r + SEEN_BITS'(1);
      if (rise) begin
        begin_pos_r   <= pos16;
        begin_frame_r <= beat.frame_number;
      end
      if (closing) begin
        in_pulse_r <= 1'b0;
        total_r    <= '0;
        count_r    <= '0;
        if (zero) begin
          halted_r <= 1'b1;
        end else begin
          pulses_r <= pulses_r + 16'd1;
        end
      end else if (pulse_now) begin
        in_pulse_r <= 1'b1;
        total_r    <= total_nxt;
        count_r    <= count_nxt;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/timing_pulse_detector.sv @@
// Top level: input register, peak level register, pulse core and result register.
//
//   channel | ports                      | dir | beat
//   in      | in_valid/in_ready/in_data   | in  | tpd_in_t: flux sample, frame number
//   out     | out_valid/out_ready/out_data| out | tpd_out_t: one finished pulse
//   cfg     | cfg_we/cfg_wdata            | in  | peak level, written on cfg_we
//
// One beat per cycle unless a result waits: a beat is held in the input register,
// is stepped through the window compares and accumulator, and its result (if any)
// is written into the output register when the beat is stepped.
// While a result waits on out_ready the step stalls; the input register holds
// one beat and in_ready drops until the result is taken.
// Synchronous active-low reset clears all window and pulse state.
`default_nettype none
module timing_pulse_detector #(
  parameter int MAX_SAMPLES = 65536
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  tpd_pkg::tpd_in_t                       in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output tpd_pkg::tpd_out_t                      out_data,
  input  logic                                   cfg_we,
  input  logic signed [tpd_pkg::SAMPLE_BITS-1:0] cfg_wdata
);
  import tpd_pkg::*;

  tpd_in_t                       in_data_r;
  logic                          in_valid_r;
  logic signed [SAMPLE_BITS-1:0] peak_r;
  tpd_out_t                      out_data_r;
  logic                          out_valid_r;

  logic                          step, emit;
  tpd_out_t                      result;

  assign step     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;

  tpd_pulse_acc #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .beat   (in_data_r),
    .peak   (peak_r),
    .emit   (emit),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      peak_r      <= '0;
    end else begin
      if (cfg_we) begin
        peak_r <= cfg_wdata;
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
    if (emit) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

@@ dv/timing_pulse_detector_tb.sv @@
// Testbench for timing_pulse_detector: directed and random flux streams checked against a predictor.
`timescale 1ns / 100ps
module timing_pulse_detector_tb;
  import tpd_pkg::*;

  localparam int SAMPLE_LIMIT = 65536;
  localparam int FLUX_MAX     = 8388607;
  localparam int FLUX_MIN     = -8388608;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  tpd_in_t                       in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  tpd_out_t                      out_data;
  logic                          cfg_we    = 1'b0;
  logic signed [SAMPLE_BITS-1:0] cfg_wdata = '0;

  always #10 clk = ~clk;

  timing_pulse_detector #(
    .MAX_SAMPLES(SAMPLE_LIMIT)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // pulse predictor state
  longint     peak_now;
  longint     win_old;
  longint     win_mid;
  longint     acc_total;
  int         n_seen;
  int         acc_count;
  bit         pulse_open;
  bit         frozen;
  bit [15:0]  rise_pos;
  bit [15:0]  rise_frame;
  bit [15:0]  pulse_idx;
  tpd_out_t   pending_pulses[$];

  int errors      = 0;
  int beats_in    = 0;
  int pulses_seen = 0;
  int peak_writes = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_req    = 0;
  int hold_left   = 0;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 100) $display("MISMATCH: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [39:0] got, input logic [39:0] want);
    if (got !== want)
      report_mismatch($sformatf("pulse %0d %s: got %h, want %h", pulses_seen, name, got, want));
  endtask

  task automatic predict_sample(input logic signed [SAMPLE_BITS-1:0] flux,
                                input logic [FRAME_BITS-1:0] frame);
    longint   nw;
    longint   od;
    longint   md;
    bit       closing;
    bit       zero;
    tpd_out_t r;
    nw = flux;
    od = win_old;
    md = win_mid;
    closing = 1'b0;
    if (frozen || n_seen >= SAMPLE_LIMIT) return;
    if (n_seen >= 2) begin
      if (!pulse_open && 2 * od < md && 2 * od < nw && 20 * nw > 11 * peak_now) begin
        pulse_open = 1'b1;
        rise_frame = frame;
        rise_pos   = 16'(n_seen - 1);
      end
      if (pulse_open && 50 * od > 53 * md && od > 20 * nw && 20 * nw < peak_now)
        closing = 1'b1;
      if (pulse_open) begin
        acc_total = acc_total + md;
        if (acc_total > longint'(TOTAL_MAX)) acc_total = longint'(TOTAL_MAX);
        if (acc_total < longint'(TOTAL_MIN)) acc_total = longint'(TOTAL_MIN);
        if (acc_count < int'(CNT_MAX)) acc_count++;
        if (closing) begin
          zero = (acc_total == 0);
          r.start_position = rise_pos;
          r.start_frame    = rise_frame;
          r.sample_count   = acc_count[15:0];
          r.flux_total     = acc_total[39:0];
          r.pulse_number   = pulse_idx;
          r.zero_total     = zero;
          pending_pulses.push_back(r);
          pulse_open = 1'b0;
          acc_total  = 0;
          acc_count  = 0;
          if (zero) frozen = 1'b1;
          else pulse_idx++;
        end
      end
    end
    win_old = win_mid;
    win_mid = nw;
    n_seen++;
  endtask

  // result side: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    tpd_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pulses.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %h", out_data));
      end else begin
        want = pending_pulses.pop_front();
        check_field("start_position", out_data.start_position, want.start_position);
        check_field("start_frame", out_data.start_frame, want.start_frame);
        check_field("sample_count", out_data.sample_count, want.sample_count);
        check_field("flux_total", out_data.flux_total, want.flux_total);
        check_field("pulse_number", out_data.pulse_number, want.pulse_number);
        check_field("zero_total", out_data.zero_total, want.zero_total);
        pulses_seen++;
      end
    end
  end

  task automatic send_sample(input int flux, input int frame);
    tpd_in_t beat;
    beat.flux_sample  = flux[SAMPLE_BITS-1:0];
    beat.frame_number = frame[FRAME_BITS-1:0];
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    predict_sample(beat.flux_sample, beat.frame_number);
    beats_in++;
  endtask

  task automatic send_any(input int flux);
    send_sample(flux, $urandom_range(65535));
  endtask

  task automatic set_pace(input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
  endtask

  // drain all expected results, then let in-flight beats settle
  task automatic wait_quiet;
    in_valid <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_peak(input int value);
    wait_quiet;
    cfg_we    <= 1'b1;
    cfg_wdata <= value[SAMPLE_BITS-1:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
    peak_now = value;
    peak_writes++;
  endtask

  // rise window: low sample, then two above twice its value
  task automatic send_rise(input int pk, output int top);
    int lo;
    int mid;
    lo  = int'($urandom_range(pk / 4)) - int'($urandom_range(pk / 4));
    mid = 2 * lo + 1 + int'($urandom_range(pk / 2));
    top = 11 * pk / 20 + 1 + int'($urandom_range(pk - 11 * pk / 20 - 1));
    send_any(lo);
    send_any(mid);
    send_any(top);
  endtask

  task automatic send_shaped_pulse(input int pk);
    int top;
    int fade;
    int tail;
    send_rise(pk, top);
    repeat ($urandom_range(6)) begin
      top = pk / 2 + int'($urandom_range(pk - pk / 2));
      send_any(top);
    end
    fade = int'($urandom_range(45 * top / 53));
    tail = (top - 1) / 20 - int'($urandom_range(pk / 4));
    send_any(fade);
    send_any(tail);
  endtask

  task automatic test_window_fill_extremes;
    set_pace(0, 0);
    send_sample(FLUX_MAX, 0);
    send_sample(FLUX_MIN, 65535);
    send_sample(FLUX_MAX, 0);
    send_sample(FLUX_MIN, 65535);
    send_any(0);
    send_any(1);
    send_any(0);
    send_any(-1);
  endtask

  task automatic test_rise_and_fall_together;
    write_peak(FLUX_MIN);
    send_any(-5000000);
    send_any(-6000000);
    send_any(-500000);
  endtask

  task automatic test_plain_pulse;
    write_peak(FLUX_MAX);
    send_any(0);
    send_any(100);
    send_any(5000000);
    send_any(FLUX_MAX);
    send_any(FLUX_MAX);
    send_any(7000000);
    send_any(0);
  endtask

  task automatic test_random_stream(input int n_beats, input int idle, input int stall,
                                    input int pk);
    int stop_at;
    int pick;
    int top;
    write_peak(pk);
    set_pace(idle, stall);
    stop_at = beats_in + n_beats;
    while (beats_in < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_shaped_pulse(pk);
      end else if (pick < 85) begin
        send_rise(pk, top);
        repeat ($urandom_range(1, 3)) send_any($urandom());
      end else begin
        repeat ($urandom_range(1, 4)) send_any($urandom());
      end
    end
  endtask

  // one single-beat pulse every three beats; output held off so the block backs up
  task automatic test_backpressure;
    write_peak(FLUX_MIN);
    set_pace(0, 0);
    hold_req = 300;
    repeat (20) begin
      send_any(-5000000);
      send_any(-6000000);
      send_any(-500000);
    end
    wait_quiet;
    set_pace(0, 68);
    repeat (10) begin
      send_any(-5000000);
      send_any(-6000000);
      send_any(-500000);
    end
  endtask

  // a normal pulse, then one whose sum is zero; later beats are ignored
  task automatic test_zero_sum_halt;
    write_peak(1000);
    set_pace(0, 0);
    send_any(1000);
    send_any(0);
    send_any(0);
    send_any(100);
    send_any(600);
    send_any(-700);
    send_any(0);
    send_any(100);
    send_any(600);
    send_any(-700);
    send_any(0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_window_fill_extremes;
    test_rise_and_fall_together;
    test_plain_pulse;
    test_random_stream(300, 0, 0, $urandom_range(64, FLUX_MAX));
    test_random_stream(300, 68, 0, 100);
    test_random_stream(300, 0, 68, $urandom_range(64, FLUX_MAX));
    test_random_stream(300, 21, 21, FLUX_MAX);
    test_backpressure;
    test_zero_sum_halt;
    wait_quiet;
    repeat (20) @(posedge clk);
    $display("Ran %0d sample beats, %0d pulses compared, %0d peak level settings;",
             beats_in, pulses_seen, peak_writes);
    $display("included output hold-off, idle gaps, rise and fall in one step and the zero-sum halt.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d pulses still outstanding", pending_pulses.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
